// ===== src/mva_pkg.sv =====
// Shared types and constants for the MIDI voice allocator.
package mva_pkg;

    localparam int VOICES_DEFAULT = 8;

    localparam int SERIAL_W = 64;
    localparam int NOTE_W   = 7;
    localparam int MASK_W   = 8;
    localparam int VIDX_W   = 3;

    // Upper nibble of the status byte
    localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
    localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
    localparam logic [3:0] STATUS_CC       = 4'hB;

    localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
    localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;

    localparam logic [1:0] FULL_MSG_LEN = 2'd3;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_RETRIGGER = 3'd1,
        ACT_FREE      = 3'd2,
        ACT_STEAL_REL = 3'd3,
        ACT_STEAL_OLD = 3'd4,
        ACT_RELEASE   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_END      = 3'd1,
        OP_NOTE_ON  = 3'd2,
        OP_NOTE_OFF = 3'd3,
        OP_ALL_OFF  = 3'd4
    } op_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } mva_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic needs_scan;
        logic scan_last;
    } mva_sts_t;

endpackage

// ===== src/midi_voice_allocator.sv =====
// A note-on, note-off or all-off item is loaded, then scanned over every voice, then committed;
// other items go from the load straight to the commit. The voice scan visits one voice per
// cycle, comparing one 64-bit start serial per step. The result is registered at the commit.
// A new item is taken only after the last one has committed. A result waiting in the output
// register does not block the next transfer, only that item's commit.
// Reset: asynchronous, active low; all voices free, serial counter zero, no result pending.
module midi_voice_allocator #(
    parameter int VOICES = mva_pkg::VOICES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [7:0] status_byte,
    input  logic [7:0] data_one,
    input  logic [7:0] data_two,
    input  logic [1:0] msg_length,
    input  logic [2:0] ended_voice,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] action,
    output logic [2:0] voice_index,
    output logic [6:0] note_out,
    output logic [6:0] velocity_out,
    output logic [7:0] release_mask
);
    import mva_pkg::*;

    mva_cmd_t cmd;
    mva_sts_t sts;

    mva_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mva_datapath #(
        .VOICES (VOICES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .status_byte  (status_byte),
        .data_one     (data_one),
        .data_two     (data_two),
        .msg_length   (msg_length),
        .ended_voice  (ended_voice),
        .action       (action),
        .voice_index  (voice_index),
        .note_out     (note_out),
        .velocity_out (velocity_out),
        .release_mask (release_mask),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

// ===== src/mva_ctrl.sv =====
// Sequencer for the voice allocator: accept, voice scan, commit, output valid.
module mva_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  mva_pkg::mva_sts_t sts,
    output mva_pkg::mva_cmd_t cmd
);
    import mva_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_xfer, commit_ok;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign commit_ok = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.needs_scan ? S_SCAN : S_COMMIT;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (commit_ok)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A new result appears only out of the commit state
    a_rise_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_COMMIT))
        else $error("result valid without commit");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && sts.scan_last) |=> (state_reg == S_COMMIT))
        else $error("scan did not end in commit");

    // Commit waits while an untaken result sits in the output register
    a_commit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT && out_valid_reg && !out_ready) |=>
            (state_reg == S_COMMIT && out_valid_reg))
        else $error("result overwritten before transfer");

endmodule

// ===== src/mva_datapath.sv =====
// Voice table, serial counter, per-voice scan and result register.
module mva_datapath #(
    parameter int VOICES = mva_pkg::VOICES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              command,
    input  logic [7:0]        status_byte,
    input  logic [7:0]        data_one,
    input  logic [7:0]        data_two,
    input  logic [1:0]        msg_length,
    input  logic [2:0]        ended_voice,
    output logic [2:0]        action,
    output logic [2:0]        voice_index,
    output logic [6:0]        note_out,
    output logic [6:0]        velocity_out,
    output logic [7:0]        release_mask,
    input  mva_pkg::mva_cmd_t cmd,
    output mva_pkg::mva_sts_t sts
);
    import mva_pkg::*;

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    // Voice table
    logic [VOICES-1:0] active_reg, releasing_reg;
    logic [NOTE_W-1:0]   note_mem [VOICES];
    logic [SERIAL_W-1:0] serial_mem [VOICES];
    logic [SERIAL_W-1:0] serial_count_reg;

    // Latched item
    op_t               op_reg, op_in;
    logic [NOTE_W-1:0] note_reg, vel_reg;
    logic [2:0]        ended_reg;

    // Scan state
    logic [IDX_W-1:0]    scan_idx_reg;
    logic                match_found_reg, free_found_reg, rel_found_reg, old_found_reg;
    logic [IDX_W-1:0]    match_idx_reg, free_idx_reg, rel_idx_reg, old_idx_reg;
    logic [SERIAL_W-1:0] rel_serial_reg, old_serial_reg;
    logic [MASK_W-1:0]   mask_reg;

    // Result register
    action_t           action_reg, action_next;
    logic [IDX_W-1:0]  chosen;
    logic [2:0]        vidx_reg, vidx_next;
    logic [NOTE_W-1:0] note_out_reg, note_out_next, vel_out_reg, vel_out_next;
    logic [MASK_W-1:0] rmask_reg, rmask_next;

    // Current scanned voice
    logic                cur_act, cur_rel, cur_note_hit, cur_release;
    logic [SERIAL_W-1:0] cur_serial;
    logic [31:0]         scan_wide;
    logic                ended_ok;
    logic [IDX_W-1:0]    ended_idx;

    // Input decode
    always_comb
    begin
        op_in = OP_NONE;
        if (command)
            op_in = OP_END;
        else if (msg_length == FULL_MSG_LEN)
        begin
            if (status_byte[7:4] == STATUS_NOTE_ON && data_two[6:0] != 7'd0)
                op_in = OP_NOTE_ON;
            else if (status_byte[7:4] == STATUS_NOTE_OFF ||
                     status_byte[7:4] == STATUS_NOTE_ON)
                op_in = OP_NOTE_OFF;
            else if (status_byte[7:4] == STATUS_CC &&
                     (data_one[6:0] == CC_ALL_SOUND_OFF ||
                      data_one[6:0] == CC_ALL_NOTES_OFF))
                op_in = OP_ALL_OFF;
        end
    end

    assign sts.needs_scan = (op_in == OP_NOTE_ON) || (op_in == OP_NOTE_OFF) ||
                            (op_in == OP_ALL_OFF);
    assign sts.scan_last  = (scan_idx_reg == IDX_W'(VOICES - 1));

    assign cur_act      = active_reg[scan_idx_reg];
    assign cur_rel      = releasing_reg[scan_idx_reg];
    assign cur_serial   = serial_mem[scan_idx_reg];
    assign cur_note_hit = cur_act && (note_mem[scan_idx_reg] == note_reg);
    assign cur_release  = cur_act && ((op_reg == OP_ALL_OFF) ||
                          (op_reg == OP_NOTE_OFF && note_mem[scan_idx_reg] == note_reg));
    assign scan_wide    = 32'(scan_idx_reg);

    assign ended_ok  = (32'(ended_reg) < VOICES);
    assign ended_idx = IDX_W'(ended_reg);

    // Priority: retrigger, free, oldest releasing, oldest overall
    always_comb
    begin
        chosen        = old_idx_reg;
        action_next   = ACT_NONE;
        vidx_next     = 3'd0;
        note_out_next = '0;
        vel_out_next  = '0;
        rmask_next    = '0;
        case (op_reg)
            OP_NOTE_ON:
            begin
                if (match_found_reg)
                begin
                    chosen      = match_idx_reg;
                    action_next = ACT_RETRIGGER;
                end
                else if (free_found_reg)
                begin
                    chosen      = free_idx_reg;
                    action_next = ACT_FREE;
                end
                else if (rel_found_reg)
                begin
                    chosen      = rel_idx_reg;
                    action_next = ACT_STEAL_REL;
                end
                else
                begin
                    chosen      = old_idx_reg;
                    action_next = ACT_STEAL_OLD;
                end
                vidx_next     = 3'(chosen);
                note_out_next = note_reg;
                vel_out_next  = vel_reg;
            end
            OP_NOTE_OFF, OP_ALL_OFF:
            begin
                action_next = ACT_RELEASE;
                rmask_next  = mask_reg;
            end
            default: action_next = ACT_NONE;
        endcase
    end

    // Control and table flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= '0;
            releasing_reg    <= '0;
            serial_count_reg <= '0;
            op_reg           <= OP_NONE;
            scan_idx_reg     <= '0;
            match_found_reg  <= 1'b0;
            free_found_reg   <= 1'b0;
            rel_found_reg    <= 1'b0;
            old_found_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                op_reg          <= op_in;
                scan_idx_reg    <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                rel_found_reg   <= 1'b0;
                old_found_reg   <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                if (!sts.scan_last)
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                if (!match_found_reg && cur_note_hit)
                    match_found_reg <= 1'b1;
                if (!free_found_reg && !cur_act)
                    free_found_reg <= 1'b1;
                if (cur_rel)
                    rel_found_reg <= 1'b1;
                old_found_reg <= 1'b1;
                if (cur_release)
                    releasing_reg[scan_idx_reg] <= 1'b1;
            end
            if (cmd.commit)
            begin
                if (op_reg == OP_NOTE_ON)
                begin
                    active_reg[chosen]    <= 1'b1;
                    releasing_reg[chosen] <= 1'b0;
                    serial_count_reg      <= serial_count_reg + SERIAL_W'(1);
                end
                else if (op_reg == OP_END && ended_ok)
                begin
                    active_reg[ended_idx]    <= 1'b0;
                    releasing_reg[ended_idx] <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            note_reg  <= data_one[6:0];
            vel_reg   <= data_two[6:0];
            ended_reg <= ended_voice;
            mask_reg  <= '0;
        end
        if (cmd.scan_step)
        begin
            if (!match_found_reg && cur_note_hit)
                match_idx_reg <= scan_idx_reg;
            if (!free_found_reg && !cur_act)
                free_idx_reg <= scan_idx_reg;
            if (cur_rel && (!rel_found_reg || cur_serial < rel_serial_reg))
            begin
                rel_idx_reg    <= scan_idx_reg;
                rel_serial_reg <= cur_serial;
            end
            if (!old_found_reg || cur_serial < old_serial_reg)
            begin
                old_idx_reg    <= scan_idx_reg;
                old_serial_reg <= cur_serial;
            end
            if (cur_release && scan_wide < MASK_W)
                mask_reg[scan_wide[2:0]] <= 1'b1;
        end
        if (cmd.commit)
        begin
            if (op_reg == OP_NOTE_ON)
            begin
                note_mem[chosen]   <= note_reg;
                serial_mem[chosen] <= serial_count_reg + SERIAL_W'(1);
            end
            action_reg   <= action_next;
            vidx_reg     <= vidx_next;
            note_out_reg <= note_out_next;
            vel_out_reg  <= vel_out_next;
            rmask_reg    <= rmask_next;
        end
    end

    assign action       = action_reg;
    assign voice_index  = vidx_reg;
    assign note_out     = note_out_reg;
    assign velocity_out = vel_out_reg;
    assign release_mask = rmask_reg;

    // Releasing is only ever set on a sounding voice
    a_rel_implies_active: assert property (@(posedge clk) disable iff (!rst_n)
        (releasing_reg & ~active_reg) == '0)
        else $error("releasing voice not active");

    a_note_on_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && op_reg == OP_NOTE_ON) |=>
            (action_reg != ACT_NONE && action_reg != ACT_RELEASE))
        else $error("note-on gave no voice");

    a_serial_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && op_reg == OP_NOTE_ON) |=>
            (serial_count_reg == $past(serial_count_reg) + SERIAL_W'(1)))
        else $error("serial counter did not advance");

endmodule

// ===== tb/sv/midi_voice_allocator_checker.sv =====
// Checker for the MIDI voice allocator: voice-table predictor and in-order result compare.
module midi_voice_allocator_checker #(
    parameter int VOICES = mva_pkg::VOICES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       command,
    input  logic [7:0] status_byte,
    input  logic [7:0] data_one,
    input  logic [7:0] data_two,
    input  logic [1:0] msg_length,
    input  logic [2:0] ended_voice,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] action,
    input  logic [2:0] voice_index,
    input  logic [6:0] note_out,
    input  logic [6:0] velocity_out,
    input  logic [7:0] release_mask,
    output int         mismatches,
    output int         pending,
    output int         action_seen [6]
);
    timeunit 1ns;
    timeprecision 1ps;

    import mva_pkg::*;

    typedef struct packed {
        action_t             act;
        logic [VIDX_W-1:0]   vidx;
        logic [NOTE_W-1:0]   note;
        logic [NOTE_W-1:0]   vel;
        logic [MASK_W-1:0]   mask;
    } voice_result_t;

    logic                active_q    [VOICES];
    logic                releasing_q [VOICES];
    logic [NOTE_W-1:0]   note_q      [VOICES];
    logic [SERIAL_W-1:0] serial_q    [VOICES];
    logic [SERIAL_W-1:0] serial_ctr;

    voice_result_t expected_results [$];
    int            err_count;

    assign mismatches = err_count;

    initial begin
        err_count = 0;
        pending   = 0;
        foreach (action_seen[a]) action_seen[a] = 0;
    end

    // Updates the voice table for one transfer and returns the result it should produce.
    function automatic voice_result_t allocate_voice(input logic cmd, input logic [7:0] st,
                                                     input logic [7:0] d1, input logic [7:0] d2,
                                                     input logic [1:0] len, input logic [2:0] ev);
        voice_result_t       r;
        logic [NOTE_W-1:0]   n;
        logic [NOTE_W-1:0]   v;
        logic [SERIAL_W-1:0] best;
        int                  chosen;
        int                  i;
        r      = '0;
        r.act  = ACT_NONE;
        n      = d1[6:0];
        v      = d2[6:0];
        chosen = -1;
        best   = '0;
        if (cmd) begin
            if (int'(ev) < VOICES) begin
                active_q[ev]    = 1'b0;
                releasing_q[ev] = 1'b0;
            end
        end else if (len >= FULL_MSG_LEN) begin
            if (st[7:4] == STATUS_NOTE_ON && v != 0) begin
                for (i = 0; i < VOICES; i++)
                    if (chosen < 0 && active_q[i] && note_q[i] == n) begin
                        chosen = i;
                        r.act  = ACT_RETRIGGER;
                    end
                for (i = 0; i < VOICES; i++)
                    if (chosen < 0 && !active_q[i]) begin
                        chosen = i;
                        r.act  = ACT_FREE;
                    end
                if (chosen < 0) begin
                    // strict less-than keeps the lowest index on a serial tie
                    for (i = 0; i < VOICES; i++)
                        if (releasing_q[i] && (chosen < 0 || serial_q[i] < best)) begin
                            chosen = i;
                            best   = serial_q[i];
                        end
                    if (chosen >= 0)
                        r.act = ACT_STEAL_REL;
                end
                if (chosen < 0) begin
                    for (i = 0; i < VOICES; i++)
                        if (chosen < 0 || serial_q[i] < best) begin
                            chosen = i;
                            best   = serial_q[i];
                        end
                    r.act = ACT_STEAL_OLD;
                end
                serial_ctr          = serial_ctr + 1'b1;
                active_q[chosen]    = 1'b1;
                releasing_q[chosen] = 1'b0;
                note_q[chosen]      = n;
                serial_q[chosen]    = serial_ctr;
                r.vidx              = chosen[VIDX_W-1:0];
                r.note              = n;
                r.vel               = v;
            end else if (st[7:4] == STATUS_NOTE_OFF || st[7:4] == STATUS_NOTE_ON) begin
                for (i = 0; i < VOICES; i++)
                    if (active_q[i] && note_q[i] == n) begin
                        releasing_q[i] = 1'b1;
                        if (i < MASK_W)
                            r.mask[i] = 1'b1;
                    end
                r.act = ACT_RELEASE;
            end else if (st[7:4] == STATUS_CC &&
                         (n == CC_ALL_SOUND_OFF || n == CC_ALL_NOTES_OFF)) begin
                for (i = 0; i < VOICES; i++)
                    if (active_q[i]) begin
                        releasing_q[i] = 1'b1;
                        if (i < MASK_W)
                            r.mask[i] = 1'b1;
                    end
                r.act = ACT_RELEASE;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        voice_result_t exp_r;
        if (!rst_n) begin
            for (int i = 0; i < VOICES; i++) begin
                active_q[i]    = 1'b0;
                releasing_q[i] = 1'b0;
                note_q[i]      = '0;
                serial_q[i]    = '0;
            end
            serial_ctr = '0;
            expected_results.delete();
            pending <= 0;
        end else begin
            // results first: a result can never belong to a transfer of the same edge
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    err_count++;
                    $error("result with no transfer waiting: action %0d", action);
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("action", 8'(exp_r.act), 8'(action));
                    check_field("voice_index", 8'(exp_r.vidx), 8'(voice_index));
                    check_field("note_out", 8'(exp_r.note), 8'(note_out));
                    check_field("velocity_out", 8'(exp_r.vel), 8'(velocity_out));
                    check_field("release_mask", exp_r.mask, release_mask);
                    if (int'(exp_r.act) < 6)
                        action_seen[exp_r.act]++;
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(allocate_voice(command, status_byte, data_one,
                                                          data_two, msg_length, ended_voice));
            pending <= expected_results.size();
        end
    end

endmodule

// ===== tb/sv/midi_voice_allocator_tb.sv =====
// Testbench top for the MIDI voice allocator: clock, reset, stimulus and verdict.
module midi_voice_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mva_pkg::*;

    localparam int VOICES         = VOICES_DEFAULT;
    localparam int RANDOM_ITEMS   = 630;
    localparam int CALM_TAIL      = 80;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic       cmd;
        logic [7:0] st;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [1:0] len;
        logic [2:0] ev;
    } midi_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       command = 1'b0;
    logic [7:0] status_byte = '0;
    logic [7:0] data_one = '0;
    logic [7:0] data_two = '0;
    logic [1:0] msg_length = '0;
    logic [2:0] ended_voice = '0;
    logic       out_valid;
    logic       out_ready = 1'b1;
    logic [2:0] action;
    logic [2:0] voice_index;
    logic [6:0] note_out;
    logic [6:0] velocity_out;
    logic [7:0] release_mask;

    logic       calm = 1'b0;
    int         stall_left = 0;
    int         quiet_cycles = 0;
    int         items_sent = 0;
    int         mismatches;
    int         pending;
    int         action_seen [6];

    always #2 clk = ~clk;

    midi_voice_allocator #(.VOICES(VOICES)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .status_byte(status_byte), .data_one(data_one),
        .data_two(data_two), .msg_length(msg_length), .ended_voice(ended_voice),
        .out_valid(out_valid), .out_ready(out_ready),
        .action(action), .voice_index(voice_index), .note_out(note_out),
        .velocity_out(velocity_out), .release_mask(release_mask)
    );

    midi_voice_allocator_checker #(.VOICES(VOICES)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .status_byte(status_byte), .data_one(data_one),
        .data_two(data_two), .msg_length(msg_length), .ended_voice(ended_voice),
        .out_valid(out_valid), .out_ready(out_ready),
        .action(action), .voice_index(voice_index), .note_out(note_out),
        .velocity_out(velocity_out), .release_mask(release_mask),
        .mismatches(mismatches), .pending(pending), .action_seen(action_seen)
    );

    // receiver stalls in random bursts unless calm
    always @(posedge clk) begin
        if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 13);
            out_ready  <= 1'b0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left <= 0;
            out_ready  <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("midi_voice_allocator: mismatch");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic midi_item_t mk(input logic cmd, input logic [7:0] st,
                                      input logic [7:0] d1, input logic [7:0] d2,
                                      input logic [1:0] len, input logic [2:0] ev);
        midi_item_t it;
        it = '{cmd: cmd, st: st, d1: d1, d2: d2, len: len, ev: ev};
        return it;
    endfunction

    // Present one item, hold it until the transfer, then maybe leave a gap.
    task automatic offer(input midi_item_t it);
        in_valid    <= 1'b1;
        command     <= it.cmd;
        status_byte <= it.st;
        data_one    <= it.d1;
        data_two    <= it.d2;
        msg_length  <= it.len;
        ended_voice <= it.ev;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        midi_item_t opening [$];
        midi_item_t it;
        int         pick;
        int         k;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        opening.push_back(mk(0, 8'h90, 8'd0, 8'd127, 2'd3, 3'd0));   // first free voice
        opening.push_back(mk(0, 8'h9F, 8'd1, 8'd127, 2'd3, 3'd0));
        opening.push_back(mk(0, 8'h95, 8'd0, 8'd64, 2'd3, 3'd0));    // same note: retrigger
        for (k = 0; k < 6; k++)
            opening.push_back(mk(0, 8'h90 | 8'(k), 8'(10 + k), 8'(20 + k), 2'd3, 3'd0));
        opening.push_back(mk(0, 8'h90, 8'd60, 8'd100, 2'd3, 3'd0));  // table full, none releasing
        opening.push_back(mk(0, 8'h80, 8'd10, 8'd0, 2'd3, 3'd0));
        opening.push_back(mk(0, 8'h9C, 8'd11, 8'd0, 2'd3, 3'd0));    // velocity zero is a note-off
        opening.push_back(mk(0, 8'h8F, 8'd99, 8'd55, 2'd3, 3'd0));   // no voice on this note
        opening.push_back(mk(0, 8'h80, 8'd10, 8'd0, 2'd3, 3'd0));    // already releasing
        opening.push_back(mk(0, 8'h90, 8'd70, 8'd1, 2'd3, 3'd0));    // steal oldest releasing
        opening.push_back(mk(0, 8'hB0, 8'd120, 8'd0, 2'd3, 3'd0));
        opening.push_back(mk(0, 8'hB3, 8'd123, 8'd0, 2'd3, 3'd0));
        opening.push_back(mk(0, 8'hB0, 8'd7, 8'd100, 2'd3, 3'd0));   // other controller
        opening.push_back(mk(1, 8'h00, 8'd0, 8'd0, 2'd0, 3'd7));
        opening.push_back(mk(1, 8'hFF, 8'hFF, 8'hFF, 2'd3, 3'd7));   // end of a free voice
        opening.push_back(mk(0, 8'h90, 8'hFF, 8'hFF, 2'd3, 3'd0));   // top bits masked off
        opening.push_back(mk(0, 8'h90, 8'd40, 8'd90, 2'd0, 3'd0));   // short messages
        opening.push_back(mk(0, 8'h90, 8'd40, 8'd90, 2'd1, 3'd0));
        opening.push_back(mk(0, 8'h80, 8'd0, 8'd90, 2'd2, 3'd0));
        opening.push_back(mk(0, 8'hE0, 8'd40, 8'd90, 2'd3, 3'd0));   // other status types
        opening.push_back(mk(0, 8'h00, 8'd40, 8'd90, 2'd3, 3'd0));
        opening.push_back(mk(0, 8'hFF, 8'd123, 8'd90, 2'd3, 3'd0));
        foreach (opening[i])
            offer(opening[i]);

        // let everything come back before random traffic
        drain_results();

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 200)
                calm <= 1'b1;
            else if (k == 260)
                calm <= 1'b0;
            else if (k == RANDOM_ITEMS - CALM_TAIL)
                calm <= 1'b1;
            if (k == 330)
                drain_results();
            pick = $urandom_range(0, 99);
            it   = mk(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 8'($urandom),
                      2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
            if (pick < 45) begin
                it.cmd = 1'b0;
                it.st  = 8'h90 | 8'($urandom_range(0, 15));
                it.d1  = 8'(48 + $urandom_range(0, 11)) |
                         ($urandom_range(0, 9) == 0 ? 8'h80 : 8'h00);
                it.d2  = 8'($urandom_range(1, 127)) | ($urandom_range(0, 1) ? 8'h80 : 8'h00);
                it.len = FULL_MSG_LEN;
            end else if (pick < 70) begin
                it.cmd = 1'b0;
                it.d1  = 8'(48 + $urandom_range(0, 11));
                it.len = FULL_MSG_LEN;
                if ($urandom_range(0, 1)) begin
                    it.st = 8'h80 | 8'($urandom_range(0, 15));
                end else begin
                    it.st = 8'h90 | 8'($urandom_range(0, 15));
                    it.d2 = $urandom_range(0, 1) ? 8'h80 : 8'h00;
                end
            end else if (pick < 85) begin
                it.cmd = 1'b1;
            end else if (pick < 90) begin
                it.cmd = 1'b0;
                it.st  = 8'hB0 | 8'($urandom_range(0, 15));
                it.len = FULL_MSG_LEN;
                case ($urandom_range(0, 2))
                    0: it.d1 = 8'(CC_ALL_SOUND_OFF);
                    1: it.d1 = 8'(CC_ALL_NOTES_OFF);
                    default: ;
                endcase
            end
            offer(it);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2 * (VOICES + 2)) @(posedge clk);

        if (pending != 0)
            $error("%0d results never arrived", pending);
        $display("covered %0d transfers incl. directed cases, short and foreign messages",
                 items_sent);
        $display({"results: %0d retrigger, %0d free, %0d steal-releasing, ",
                  "%0d steal-oldest, %0d release, %0d none"},
                 action_seen[ACT_RETRIGGER], action_seen[ACT_FREE], action_seen[ACT_STEAL_REL],
                 action_seen[ACT_STEAL_OLD], action_seen[ACT_RELEASE], action_seen[ACT_NONE]);
        if (mismatches == 0 && pending == 0)
            $display("midi_voice_allocator: match");
        else
            $display("midi_voice_allocator: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
src/mva_pkg.sv
src/mva_ctrl.sv
src/mva_datapath.sv
src/midi_voice_allocator.sv
tb/sv/midi_voice_allocator_checker.sv
tb/sv/midi_voice_allocator_tb.sv
